>>> hdl/path_arclength_reparametrizer_unit_macros.svh
// Assertion macros used by the checker file of the reparametrizer
`ifndef PATH_ARCLENGTH_REPARAMETRIZER_UNIT_MACROS_SVH
`define PATH_ARCLENGTH_REPARAMETRIZER_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define PAR_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("reparametrizer check failed");

// Consequent must hold in the same cycle as the antecedent
`define PAR_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("reparametrizer check failed");

`endif

>>> hdl/par_pkg.sv
// Types, codes and fixed widths shared by the reparametrizer modules
package par_pkg;

    localparam int ARC_SLOTS = 16;
    localparam int ARC_W     = 48;
    localparam int SCL_W     = 52;
    localparam int ACC_W     = 64;
    localparam int SMP_W     = 24;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_PATH = 2'd1;
    localparam logic [1:0] STATUS_NOT_READY = 2'd2;

    localparam logic REG_IMAGE_COUNT   = 1'b0;
    localparam logic REG_ELEMENT_COUNT = 1'b1;

    localparam logic [4:0]  IMAGE_COUNT_RST   = 5'd3;
    localparam logic [12:0] ELEMENT_COUNT_RST = 13'd4096;

    typedef struct packed {
        logic        mode;
        logic [3:0]  image_index;
        logic [11:0] element_index;
        logic [23:0] sample_value;
        logic        load_last;
    } in_word_t;

    typedef struct packed {
        logic [23:0] result_value;
        logic [1:0]  status;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_A_INIT,
        OP_A_RDA,
        OP_A_RDB,
        OP_A_SQ,
        OP_A_ACC,
        OP_A_SQRT,
        OP_A_NEXT,
        OP_I_T,
        OP_I_MUL,
        OP_I_CMP,
        OP_R_START,
        OP_R_DWAIT,
        OP_R_K,
        OP_R_LO,
        OP_R_HI,
        OP_R_TOT,
        OP_R_NUM,
        OP_R_MUL,
        OP_R_ADD,
        OP_R_DIV,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic e_last;
        logic j_last;
        logic total_zero;
        logic sqrt_last;
        logic hit;
        logic k_last;
        logic jj_last;
        logic not_ready;
        logic direct;
        logic zero_intv;
        logic mul_last;
        logic div_last;
    } sts_t;

endpackage

>>> hdl/par_ctrl.sv
// Sequencer for loads, arc length computation and direct or interpolated reads
module par_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    input  logic            in_last,
    input  logic            out_stall,
    input  par_pkg::sts_t   sts,
    output par_pkg::cmd_t   cmd,
    output logic            in_stall,
    output logic            out_valid
);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_A_INIT  = 22'h000002,
        S_A_RDA   = 22'h000004,
        S_A_RDB   = 22'h000008,
        S_A_SQ    = 22'h000010,
        S_A_ACC   = 22'h000020,
        S_A_SQRT  = 22'h000040,
        S_A_NEXT  = 22'h000080,
        S_I_T     = 22'h000100,
        S_I_MUL   = 22'h000200,
        S_I_CMP   = 22'h000400,
        S_R_START = 22'h000800,
        S_R_DWAIT = 22'h001000,
        S_R_K     = 22'h002000,
        S_R_LO    = 22'h004000,
        S_R_HI    = 22'h008000,
        S_R_TOT   = 22'h010000,
        S_R_NUM   = 22'h020000,
        S_R_MUL   = 22'h040000,
        S_R_ADD   = 22'h080000,
        S_R_DIV   = 22'h100000,
        S_FINISH  = 22'h200000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = par_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = par_pkg::OP_ACCEPT;
                    if (in_mode == par_pkg::MODE_READ)
                        state_next = S_R_START;
                    else if (in_last)
                        state_next = S_A_INIT;
                end
            end
            S_A_INIT:
            begin
                cmd.op     = par_pkg::OP_A_INIT;
                state_next = S_A_RDA;
            end
            S_A_RDA:
            begin
                cmd.op     = par_pkg::OP_A_RDA;
                state_next = S_A_RDB;
            end
            S_A_RDB:
            begin
                cmd.op     = par_pkg::OP_A_RDB;
                state_next = S_A_SQ;
            end
            S_A_SQ:
            begin
                cmd.op     = par_pkg::OP_A_SQ;
                state_next = S_A_ACC;
            end
            S_A_ACC:
            begin
                cmd.op     = par_pkg::OP_A_ACC;
                state_next = sts.e_last ? S_A_SQRT : S_A_RDA;
            end
            S_A_SQRT:
            begin
                cmd.op = par_pkg::OP_A_SQRT;
                if (sts.sqrt_last)
                    state_next = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                cmd.op = par_pkg::OP_A_NEXT;
                if (!sts.j_last)
                    state_next = S_A_RDA;
                else if (sts.total_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_I_T;
            end
            S_I_T:
            begin
                cmd.op     = par_pkg::OP_I_T;
                state_next = S_I_MUL;
            end
            S_I_MUL:
            begin
                cmd.op     = par_pkg::OP_I_MUL;
                state_next = S_I_CMP;
            end
            S_I_CMP:
            begin
                cmd.op = par_pkg::OP_I_CMP;
                if (sts.hit || sts.k_last)
                    state_next = sts.jj_last ? S_IDLE : S_I_T;
                else
                    state_next = S_I_MUL;
            end
            S_R_START:
            begin
                cmd.op = par_pkg::OP_R_START;
                if (sts.not_ready)
                    state_next = S_FINISH;
                else if (sts.direct)
                    state_next = S_R_DWAIT;
                else
                    state_next = S_R_K;
            end
            S_R_DWAIT:
            begin
                cmd.op     = par_pkg::OP_R_DWAIT;
                state_next = S_FINISH;
            end
            S_R_K:
            begin
                cmd.op     = par_pkg::OP_R_K;
                state_next = S_R_LO;
            end
            S_R_LO:
            begin
                cmd.op     = par_pkg::OP_R_LO;
                state_next = S_R_HI;
            end
            S_R_HI:
            begin
                cmd.op     = par_pkg::OP_R_HI;
                state_next = S_R_TOT;
            end
            S_R_TOT:
            begin
                cmd.op     = par_pkg::OP_R_TOT;
                state_next = sts.zero_intv ? S_FINISH : S_R_NUM;
            end
            S_R_NUM:
            begin
                cmd.op     = par_pkg::OP_R_NUM;
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                cmd.op = par_pkg::OP_R_MUL;
                if (sts.mul_last)
                    state_next = S_R_ADD;
            end
            S_R_ADD:
            begin
                cmd.op     = par_pkg::OP_R_ADD;
                state_next = S_R_DIV;
            end
            S_R_DIV:
            begin
                cmd.op = par_pkg::OP_R_DIV;
                if (sts.div_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = par_pkg::OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == par_pkg::OP_OUT_LOAD)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/par_dp.sv
// Sample store, arc length registers and iterative arithmetic of the reparametrizer
module par_dp
#(
    parameter int MAX_IMAGES   = 16,
    parameter int MAX_ELEMENTS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  par_pkg::cmd_t       cmd,
    input  par_pkg::in_word_t   in_word,
    input  logic [4:0]          image_count,
    input  logic [12:0]         element_count,
    input  logic                cfg_clear,
    output par_pkg::sts_t       sts,
    output par_pkg::out_word_t  out_word
);

    localparam int DEPTH = MAX_IMAGES * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int XW    = (EW > 12) ? EW : 12;
    localparam int MW    = $clog2(MAX_ELEMENTS + 1);
    localparam int NHI   = (MAX_IMAGES < par_pkg::ARC_SLOTS) ? MAX_IMAGES : par_pkg::ARC_SLOTS;
    localparam logic [AW-1:0] ROW = AW'(MAX_ELEMENTS);
    localparam logic [63:0]   SQRT_BIT0 = 64'h4000_0000_0000_0000;

    function automatic logic [AW-1:0] addr_of(input logic [3:0] img, input logic [XW-1:0] el);
        return AW'(AW'(img) * ROW) + AW'(el);
    endfunction

    logic [23:0] store_mem [DEPTH];
    logic [23:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic        wr_en;

    logic        ready_reg;
    logic        degen_reg;

    logic [3:0]  img_reg;
    logic [11:0] el_reg;
    logic [3:0]  j_reg;
    logic [EW-1:0] e_reg;
    logic [63:0] acc_reg;
    logic [23:0] a_reg;
    logic [47:0] sq_reg;
    logic [63:0] val_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [5:0]  iter_reg;
    logic [47:0] arc_prev_reg;
    logic [47:0] total_reg;
    logic [47:0] arc_reg [par_pkg::ARC_SLOTS];
    logic [3:0]  intv_reg [par_pkg::ARC_SLOTS];
    logic [3:0]  jj_reg;
    logic [3:0]  k_reg;
    logic [51:0] t_reg;
    logic [51:0] lo_reg;
    logic [51:0] hi_reg;
    logic [47:0] lo_arc_reg;
    logic [47:0] hi_arc_reg;
    logic [23:0] y0_reg;
    logic [23:0] y1_reg;
    logic [51:0] den_reg;
    logic [51:0] ma_reg;
    logic [51:0] mb_reg;
    logic [23:0] res_reg;
    logic [1:0]  stat_reg;
    par_pkg::out_word_t out_word_reg;

    logic [4:0]    n_cnt;
    logic [MW-1:0] m_cnt;
    logic [3:0]    nm1;
    logic [3:0]    nm2;
    logic [3:0]    kp1;
    logic [3:0]    kc;
    logic          in_store_wr;
    logic          in_store_rd;
    logic [23:0]   diff;
    logic [63:0]   acc_sum;
    logic [63:0]   sq_rb;
    logic          sq_ge;
    logic [63:0]   sq_val_n;
    logic [63:0]   sq_root_n;
    logic [47:0]   arc_sum;
    logic [63:0]   mul_n;
    logic [63:0]   rem_sh;
    logic          div_ge;
    logic [63:0]   rem_n;
    logic [63:0]   quot_n;
    logic [51:0]   num_raw;
    logic [51:0]   num_c;

    always_comb
    begin
        if (image_count < 5'd3)
            n_cnt = 5'd3;
        else if (32'(image_count) > NHI)
            n_cnt = 5'(NHI);
        else
            n_cnt = image_count;
        if (element_count == 13'd0)
            m_cnt = MW'(1);
        else if (32'(element_count) > MAX_ELEMENTS)
            m_cnt = MW'(MAX_ELEMENTS);
        else
            m_cnt = MW'(element_count);
    end

    assign nm1 = 4'(n_cnt - 5'd1);
    assign nm2 = 4'(n_cnt - 5'd2);
    assign kp1 = k_reg + 4'd1;

    assign in_store_wr = (32'(in_word.image_index) < MAX_IMAGES)
                      && (32'(in_word.element_index) < MAX_ELEMENTS);
    assign in_store_rd = (32'(img_reg) < MAX_IMAGES) && (32'(el_reg) < MAX_ELEMENTS);
    assign wr_en = (cmd.op == par_pkg::OP_ACCEPT) && (in_word.mode == par_pkg::MODE_LOAD)
                && in_store_wr;

    always_comb
    begin
        case (cmd.op)
            par_pkg::OP_A_RDA:   raddr = addr_of(j_reg - 4'd1, XW'(e_reg));
            par_pkg::OP_A_RDB:   raddr = addr_of(j_reg, XW'(e_reg));
            par_pkg::OP_R_START: raddr = addr_of(img_reg, XW'(el_reg));
            par_pkg::OP_R_LO:    raddr = addr_of(k_reg, XW'(el_reg));
            par_pkg::OP_R_HI:    raddr = addr_of(kp1, XW'(el_reg));
            default:             raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[addr_of(in_word.image_index, XW'(in_word.element_index))]
                <= in_word.sample_value;
        rdata_reg <= store_mem[raddr];
    end

    assign diff    = (a_reg >= rdata_reg) ? (a_reg - rdata_reg) : (rdata_reg - a_reg);
    assign acc_sum = acc_reg + 64'(sq_reg);

    assign sq_rb     = root_reg + bit_reg;
    assign sq_ge     = (val_reg >= sq_rb);
    assign sq_val_n  = sq_ge ? (val_reg - sq_rb) : val_reg;
    assign sq_root_n = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign arc_sum   = arc_prev_reg + root_reg[47:0];

    assign mul_n = {acc_reg[62:0], 1'b0}
                 + (y0_reg[23] ? 64'(ma_reg) : 64'd0)
                 + (y1_reg[23] ? 64'(mb_reg) : 64'd0);

    assign rem_sh = {root_reg[62:0], val_reg[63]};
    assign div_ge = (rem_sh >= 64'(den_reg));
    assign rem_n  = div_ge ? (rem_sh - 64'(den_reg)) : rem_sh;
    assign quot_n = {val_reg[62:0], div_ge};

    assign num_raw = (t_reg > lo_reg) ? (t_reg - lo_reg) : 52'd0;
    assign num_c   = (num_raw > den_reg) ? den_reg : num_raw;

    always_comb
    begin
        if (5'(intv_reg[img_reg]) + 5'd1 >= n_cnt)
            kc = nm2;
        else
            kc = intv_reg[img_reg];
    end

    always_comb
    begin
        sts.e_last     = (32'(e_reg) == 32'(m_cnt) - 32'd1);
        sts.j_last     = (j_reg == nm1);
        sts.total_zero = (arc_sum == 48'd0);
        sts.sqrt_last  = (iter_reg == 6'd31);
        sts.hit        = (t_reg >= lo_reg) && (t_reg < hi_reg);
        sts.k_last     = (k_reg == nm2);
        sts.jj_last    = (jj_reg == nm2);
        sts.not_ready  = !ready_reg;
        sts.direct     = degen_reg || (img_reg == 4'd0)
                      || (5'(img_reg) + 5'd1 >= n_cnt)
                      || (32'(el_reg) >= 32'(m_cnt));
        sts.zero_intv  = (hi_arc_reg <= lo_arc_reg);
        sts.mul_last   = (iter_reg == 6'd23);
        sts.div_last   = (iter_reg == 6'd63);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            degen_reg <= 1'b0;
        end
        else if (cfg_clear)
        begin
            ready_reg <= 1'b0;
            degen_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                par_pkg::OP_ACCEPT:
                begin
                    if (in_word.mode == par_pkg::MODE_LOAD)
                    begin
                        ready_reg <= 1'b0;
                        degen_reg <= 1'b0;
                    end
                end
                par_pkg::OP_A_NEXT:
                begin
                    if (sts.j_last && sts.total_zero)
                    begin
                        ready_reg <= 1'b1;
                        degen_reg <= 1'b1;
                    end
                end
                par_pkg::OP_I_CMP:
                begin
                    if ((sts.hit || sts.k_last) && sts.jj_last)
                        ready_reg <= 1'b1;
                end
                default:
                begin
                    ready_reg <= ready_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            par_pkg::OP_ACCEPT:
            begin
                img_reg <= in_word.image_index;
                el_reg  <= in_word.element_index;
            end
            par_pkg::OP_A_INIT:
            begin
                j_reg        <= 4'd1;
                e_reg        <= '0;
                acc_reg      <= '0;
                arc_prev_reg <= '0;
                arc_reg[0]   <= '0;
            end
            par_pkg::OP_A_RDB:
            begin
                a_reg <= rdata_reg;
            end
            par_pkg::OP_A_SQ:
            begin
                sq_reg <= 48'(diff) * 48'(diff);
            end
            par_pkg::OP_A_ACC:
            begin
                acc_reg <= acc_sum;
                e_reg   <= e_reg + EW'(1);
                if (sts.e_last)
                begin
                    val_reg  <= acc_sum;
                    root_reg <= '0;
                    bit_reg  <= SQRT_BIT0;
                    iter_reg <= '0;
                end
            end
            par_pkg::OP_A_SQRT:
            begin
                val_reg  <= sq_val_n;
                root_reg <= sq_root_n;
                bit_reg  <= bit_reg >> 2;
                iter_reg <= iter_reg + 6'd1;
            end
            par_pkg::OP_A_NEXT:
            begin
                arc_reg[j_reg] <= arc_sum;
                arc_prev_reg   <= arc_sum;
                total_reg      <= arc_sum;
                j_reg          <= j_reg + 4'd1;
                e_reg          <= '0;
                acc_reg        <= '0;
                jj_reg         <= 4'd1;
            end
            par_pkg::OP_I_T:
            begin
                t_reg  <= 52'(total_reg) * 52'(jj_reg);
                k_reg  <= 4'd0;
                lo_reg <= '0;
            end
            par_pkg::OP_I_MUL:
            begin
                hi_reg <= 52'(arc_reg[kp1]) * 52'(nm1);
            end
            par_pkg::OP_I_CMP:
            begin
                if (sts.hit || sts.k_last)
                begin
                    intv_reg[jj_reg] <= sts.hit ? k_reg : nm2;
                    jj_reg           <= jj_reg + 4'd1;
                end
                else
                begin
                    k_reg  <= kp1;
                    lo_reg <= hi_reg;
                end
            end
            par_pkg::OP_R_START:
            begin
                res_reg <= '0;
                if (!ready_reg)
                    stat_reg <= par_pkg::STATUS_NOT_READY;
                else if (degen_reg)
                    stat_reg <= par_pkg::STATUS_ZERO_PATH;
                else
                    stat_reg <= par_pkg::STATUS_OK;
            end
            par_pkg::OP_R_DWAIT:
            begin
                res_reg <= in_store_rd ? rdata_reg : 24'd0;
            end
            par_pkg::OP_R_K:
            begin
                k_reg <= kc;
            end
            par_pkg::OP_R_LO:
            begin
                lo_arc_reg <= arc_reg[k_reg];
            end
            par_pkg::OP_R_HI:
            begin
                y0_reg     <= rdata_reg;
                hi_arc_reg <= arc_reg[kp1];
            end
            par_pkg::OP_R_TOT:
            begin
                y1_reg  <= rdata_reg;
                den_reg <= 52'(hi_arc_reg - lo_arc_reg) * 52'(nm1);
                t_reg   <= 52'(total_reg) * 52'(img_reg);
                lo_reg  <= 52'(lo_arc_reg) * 52'(nm1);
                res_reg <= y0_reg;
            end
            par_pkg::OP_R_NUM:
            begin
                ma_reg   <= den_reg - num_c;
                mb_reg   <= num_c;
                acc_reg  <= '0;
                iter_reg <= '0;
            end
            par_pkg::OP_R_MUL:
            begin
                acc_reg  <= mul_n;
                y0_reg   <= {y0_reg[22:0], 1'b0};
                y1_reg   <= {y1_reg[22:0], 1'b0};
                iter_reg <= iter_reg + 6'd1;
            end
            par_pkg::OP_R_ADD:
            begin
                val_reg  <= acc_reg + 64'(den_reg >> 1);
                root_reg <= '0;
                iter_reg <= '0;
            end
            par_pkg::OP_R_DIV:
            begin
                val_reg  <= quot_n;
                root_reg <= rem_n;
                iter_reg <= iter_reg + 6'd1;
                if (sts.div_last)
                    res_reg <= quot_n[23:0];
            end
            par_pkg::OP_OUT_LOAD:
            begin
                out_word_reg.result_value <= res_reg;
                out_word_reg.status       <= stat_reg;
            end
            default:
            begin
                img_reg <= img_reg;
            end
        endcase
    end

    assign out_word = out_word_reg;

endmodule

>>> hdl/path_arclength_reparametrizer_unit.sv
// Top level of the arc length reparametrizer: configuration registers and unit wiring
//
// Input channel in_valid/in_stall/in_word. A load word (mode 0) writes one Q4.20
// sample; without load_last the block stays ready for the next word. With it the
// arc length pass holds in_stall over n images of m samples: read A, read B,
// square and accumulate per sample pair on the single store read port, 32 square
// root steps and one update per neighbor pair, and per interior image one setup
// step plus a multiply and a compare per interval candidate.
// A read word (mode 1) gives exactly one result word on out_valid/out_word. A
// not-ready, direct or zero-interval read skips the arithmetic; an interpolated
// read runs the 24-step shift-add multiply and the 64-step restoring divider. The
// next word is taken once the result is loaded into the output register.
// The output register holds a finished result while out_stall is high; a new
// word is accepted meanwhile, and the next result waits until the register frees.
// Reset clears the arc ready flag (reads answer status 2 until a load_last pass),
// sets image_count to 3 and element_count to 4096; the sample store is not cleared.
// Configuration is to be written through the APB port only while the block is
// idle; the block itself does not enforce this.
module path_arclength_reparametrizer_unit
#(
    parameter int MAX_IMAGES   = 16,
    parameter int MAX_ELEMENTS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  par_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output par_pkg::out_word_t  out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [4:0]    image_count_reg;
    logic [12:0]   element_count_reg;
    logic          cfg_we;
    par_pkg::cmd_t cmd;
    par_pkg::sts_t sts;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_count_reg   <= par_pkg::IMAGE_COUNT_RST;
            element_count_reg <= par_pkg::ELEMENT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                par_pkg::REG_IMAGE_COUNT:   image_count_reg   <= pwdata[4:0];
                par_pkg::REG_ELEMENT_COUNT: element_count_reg <= pwdata[12:0];
                default:                    image_count_reg   <= image_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            par_pkg::REG_IMAGE_COUNT:   prdata = {27'd0, image_count_reg};
            par_pkg::REG_ELEMENT_COUNT: prdata = {19'd0, element_count_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    par_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_word.mode),
        .in_last   (in_word.load_last),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    par_dp
    #(
        .MAX_IMAGES   (MAX_IMAGES),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_word       (in_word),
        .image_count   (image_count_reg),
        .element_count (element_count_reg),
        .cfg_clear     (cfg_we),
        .sts           (sts),
        .out_word      (out_word)
    );

endmodule

>>> hdl/par_chk.sv
// Port-level checker for the reparametrizer and its bind
`include "path_arclength_reparametrizer_unit_macros.svh"

module par_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input par_pkg::in_word_t   in_word,
    input logic                out_valid,
    input logic                out_stall,
    input par_pkg::out_word_t  out_word
);

    `PAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
    `PAR_ASSERT_NEXT(a_read_busy, in_valid && !in_stall && in_word.mode == par_pkg::MODE_READ, in_stall)
    `PAR_ASSERT_NEXT(a_load_free, in_valid && !in_stall && in_word.mode == par_pkg::MODE_LOAD && !in_word.load_last, !in_stall)
    `PAR_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && in_word.mode == par_pkg::MODE_LOAD && !out_valid, !out_valid)
    `PAR_ASSERT_NOW(a_rise_idle, $rose(out_valid), !in_stall)

endmodule

bind path_arclength_reparametrizer_unit par_chk u_par_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

>>> tb/tb.sv
// Testbench for path_arclength_reparametrizer_unit: directed and random checks against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 4000000;
    localparam int RAND_ITEMS = 520;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    par_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    par_pkg::out_word_t out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [23:0] dens_mem [0:65535];
    bit          dens_set [0:65535];
    logic [47:0] arc_pos [0:15];
    logic [3:0]  lower_img [0:15];
    bit          arcs_valid;
    bit          path_flat;
    logic [4:0]  cfg_images;
    logic [12:0] cfg_elems;
    par_pkg::out_word_t want_q [$];

    int  err_cnt;
    int  cycle_cnt;
    int  rx_wait;
    bit  rx_hold;
    bit  rx_quiet;
    bit  tx_quiet;
    int  rand_items;

    path_arclength_reparametrizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    function automatic int used_images();
        int n;
        n = cfg_images;
        if (n < 3) n = 3;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic int used_elems();
        int m;
        m = cfg_elems;
        if (m < 1) m = 1;
        if (m > 4096) m = 4096;
        return m;
    endfunction

    function automatic logic [63:0] sample(int img, int el);
        if (!dens_set[img * 4096 + el])
            return 64'd0;
        return {40'd0, dens_mem[img * 4096 + el]};
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void rebuild_arcs();
        int n;
        int m;
        int pick;
        logic [63:0] acc;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] nm1;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] step;
        n = used_images();
        m = used_elems();
        nm1 = 64'(n - 1);
        for (int i = 0; i < 16; i++)
        begin
            arc_pos[i] = '0;
            lower_img[i] = '0;
        end
        for (int j = 1; j < n; j++)
        begin
            acc = 0;
            for (int e = 0; e < m; e++)
            begin
                a = sample(j - 1, e);
                b = sample(j, e);
                d = (a > b) ? a - b : b - a;
                acc = acc + d * d;
            end
            step = isqrt64(acc);
            arc_pos[j] = arc_pos[j - 1] + step[47:0];
        end
        arcs_valid = 1;
        path_flat = (arc_pos[n - 1] == 0);
        if (path_flat)
            return;
        for (int j = 1; j + 1 < n; j++)
        begin
            t = 64'(j) * {16'd0, arc_pos[n - 1]};
            pick = n - 2;
            for (int k = 0; k + 1 < n; k++)
            begin
                lo = {16'd0, arc_pos[k]} * nm1;
                hi = {16'd0, arc_pos[k + 1]} * nm1;
                if (t >= lo && t < hi)
                begin
                    pick = k;
                    break;
                end
            end
            lower_img[j] = pick[3:0];
        end
    endfunction

    function automatic void predict(par_pkg::in_word_t w);
        int n;
        int m;
        int img;
        int el;
        int k;
        logic [63:0] nm1;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] y0;
        logic [63:0] y1;
        logic [63:0] base;
        logic [63:0] q;
        par_pkg::out_word_t r;
        img = w.image_index;
        el = w.element_index;
        if (w.mode == par_pkg::MODE_LOAD)
        begin
            dens_mem[img * 4096 + el] = w.sample_value;
            dens_set[img * 4096 + el] = 1;
            arcs_valid = 0;
            path_flat = 0;
            if (w.load_last)
                rebuild_arcs();
            return;
        end
        n = used_images();
        m = used_elems();
        if (!arcs_valid)
        begin
            r.result_value = '0;
            r.status = par_pkg::STATUS_NOT_READY;
        end
        else if (path_flat)
        begin
            q = sample(img, el);
            r.result_value = q[23:0];
            r.status = par_pkg::STATUS_ZERO_PATH;
        end
        else
        begin
            r.status = par_pkg::STATUS_OK;
            if (img == 0 || img + 1 >= n || el >= m)
            begin
                q = sample(img, el);
                r.result_value = q[23:0];
            end
            else
            begin
                k = lower_img[img];
                if (k + 1 >= n) k = n - 2;
                nm1 = 64'(n - 1);
                y0 = sample(k, el);
                y1 = sample(k + 1, el);
                if (arc_pos[k + 1] <= arc_pos[k])
                    r.result_value = y0[23:0];
                else
                begin
                    den = {16'd0, arc_pos[k + 1] - arc_pos[k]} * nm1;
                    base = {16'd0, arc_pos[k]} * nm1;
                    num = 64'(img) * {16'd0, arc_pos[n - 1]};
                    num = (num > base) ? num - base : 64'd0;
                    if (num > den) num = den;
                    q = (y0 * (den - num) + y1 * num + den / 2) / den;
                    r.result_value = q[23:0];
                end
            end
        end
        want_q = {want_q, r};
    endfunction

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected word: value %h status %0d",
                             out_word.result_value, out_word.status);
            end
            else
            begin
                if (out_word.result_value !== want_q[0].result_value ||
                    out_word.status !== want_q[0].status)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected %h/%0d, got %h/%0d",
                                 want_q[0].result_value, want_q[0].status,
                                 out_word.result_value, out_word.status);
                end
                void'(want_q.pop_front());
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
        end
        if (rx_hold || rx_wait > 0)
        begin
            out_stall <= 1'b1;
            if (rx_wait > 0) rx_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic par_pkg::in_word_t make_word(logic mode, int img, int el,
                                                    logic [23:0] val, logic last);
        par_pkg::in_word_t w;
        w.mode = mode;
        w.image_index = img[3:0];
        w.element_index = el[11:0];
        w.sample_value = val;
        w.load_last = last;
        return w;
    endfunction

    task automatic send_word(par_pkg::in_word_t w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (want_q.size() != 0) @(posedge clk);
    endtask

    task automatic reg_write(logic reg_sel, logic [31:0] val);
        int n;
        int m;
        drain();
        n = used_images();
        m = used_elems();
        repeat ((n - 1) * (4 * m + 34) + (n - 2) * (2 * n + 3) + 100) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == par_pkg::REG_IMAGE_COUNT)
            cfg_images = val[4:0];
        else
            cfg_elems = val[12:0];
        arcs_valid = 0;
        path_flat = 0;
    endtask

    // style: 0 random, 1 all images equal, 2 repeated neighbors, 3 alternating extremes
    task automatic fill_chain(int style);
        int n;
        int m;
        logic [23:0] v;
        n = used_images();
        m = used_elems();
        for (int i = 0; i < n; i++)
        begin
            for (int e = 0; e < m; e++)
            begin
                case (style)
                    1: v = (dens_set[e] && i > 0) ? dens_mem[e] : 24'($urandom());
                    2: v = (i > 0 && i % 3 == 2) ? dens_mem[(i - 1) * 4096 + e]
                                                 : 24'($urandom());
                    3: v = (i % 2) ? 24'hFFFFFF : 24'h000000;
                    default: v = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 255))
                                                             : 24'($urandom());
                endcase
                send_word(make_word(par_pkg::MODE_LOAD, i, e, v,
                                    (i == n - 1) && (e == m - 1)));
                rand_items++;
            end
        end
    endtask

    function automatic par_pkg::in_word_t read_word();
        int n;
        int m;
        int img;
        int el;
        n = used_images();
        m = used_elems();
        for (int t = 0; t < 20; t++)
        begin
            img = ($urandom_range(0, 9) < 7) ? $urandom_range(1, n - 2) : $urandom_range(0, 15);
            el = ($urandom_range(0, 9) < 8) ? $urandom_range(0, m - 1) : $urandom_range(0, 4095);
            if (dens_set[img * 4096 + el])
                return make_word(par_pkg::MODE_READ, img, el, 24'($urandom()),
                                 1'($urandom_range(0, 1)));
        end
        return make_word(par_pkg::MODE_READ, 0, 0, 24'($urandom()), 1'b0);
    endfunction

    task automatic read_some(int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            send_word(read_word());
            rand_items++;
        end
    endtask

    task automatic test_not_ready();
        send_word(make_word(par_pkg::MODE_READ, 0, 0, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 15, 4095, 24'hFFFFFF, 1'b1));
        send_word(make_word(par_pkg::MODE_READ, 7, 2048, 24'h123456, 1'b0));
        drain();
    endtask

    task automatic test_directed();
        reg_write(par_pkg::REG_IMAGE_COUNT, 32'd0);
        reg_write(par_pkg::REG_ELEMENT_COUNT, 32'd0);
        fill_chain(3);
        send_word(make_word(par_pkg::MODE_READ, 1, 0, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 0, 0, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 2, 0, 24'h0, 1'b0));
        reg_write(par_pkg::REG_IMAGE_COUNT, 32'd4);
        reg_write(par_pkg::REG_ELEMENT_COUNT, 32'd2);
        fill_chain(1);
        send_word(make_word(par_pkg::MODE_READ, 1, 1, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 3, 0, 24'h0, 1'b0));
        reg_write(par_pkg::REG_IMAGE_COUNT, 32'd31);
        fill_chain(2);
        read_some(4);
        send_word(make_word(par_pkg::MODE_READ, 15, 1, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_LOAD, 5, 0, 24'hABCDEF, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 5, 0, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_LOAD, 15, 1, 24'h0F0F0F, 1'b1));
        send_word(make_word(par_pkg::MODE_READ, 5, 1, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 3, 0, 24'h0, 1'b0));
        drain();
    endtask

    task automatic test_full_image();
        reg_write(par_pkg::REG_IMAGE_COUNT, 32'd3);
        reg_write(par_pkg::REG_ELEMENT_COUNT, 32'd64);
        tx_quiet = 1;
        fill_chain(0);
        tx_quiet = 0;
        send_word(make_word(par_pkg::MODE_READ, 1, 63, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 1, 0, 24'h0, 1'b0));
        send_word(make_word(par_pkg::MODE_READ, 2, 31, 24'h0, 1'b0));
        drain();
    endtask

    task automatic test_backpressure();
        reg_write(par_pkg::REG_IMAGE_COUNT, 32'd6);
        reg_write(par_pkg::REG_ELEMENT_COUNT, 32'd3);
        fill_chain(0);
        drain();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (800) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        tx_quiet = 1;
        read_some(8);
        tx_quiet = 0;
        drain();
    endtask

    task automatic test_random();
        int style;
        while (rand_items < RAND_ITEMS)
        begin
            reg_write(par_pkg::REG_IMAGE_COUNT, $urandom_range(0, 31));
            reg_write(par_pkg::REG_ELEMENT_COUNT,
                      ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 9);
            fill_chain(style < 6 ? 0 : style - 6);
            read_some($urandom_range(6, 20));
            if ($urandom_range(0, 4) == 0)
            begin
                send_word(make_word(par_pkg::MODE_LOAD, $urandom_range(0, 15),
                                    $urandom_range(0, 4095), 24'($urandom()),
                                    1'($urandom_range(0, 1))));
                read_some(3);
            end
        end
        tx_quiet = 0;
        rx_quiet = 0;
        drain();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        out_stall = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        rx_wait = 0;
        rx_hold = 0;
        rx_quiet = 0;
        tx_quiet = 0;
        rand_items = 0;
        arcs_valid = 0;
        path_flat = 0;
        cfg_images = par_pkg::IMAGE_COUNT_RST;
        cfg_elems = par_pkg::ELEMENT_COUNT_RST;
        for (int i = 0; i < 16; i++)
        begin
            arc_pos[i] = '0;
            lower_img[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_not_ready();
        test_directed();
        test_full_image();
        test_backpressure();
        rand_items = 0;
        test_random();
        repeat (300) @(posedge clk);
        if (err_cnt == 0 && want_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
